// ===== hw/rtl/kcg_pkg.sv =====
// Shared types, constants and arithmetic helpers for the potassium gate step unit.
`default_nettype none

package kcg_pkg;

    // Field and datapath widths
    localparam int COMP_W = 10;
    localparam int VOLT_W = 16;
    localparam int GATE_W = 16;
    localparam int DT_W   = 20;
    localparam int CFG_W  = 20;
    localparam int D_W    = 25;
    localparam int K_W    = 14;
    localparam int EXP_W  = 64;
    localparam int DIV_W  = 64;
    localparam int Q_W    = 35;
    localparam int TAU_W  = 50;
    localparam int NUM_W  = 56;
    localparam int CUR_W  = 32;

    // Configuration register indexes
    localparam logic REG_TIME_STEP = 1'b0;
    localparam logic REG_REVERSAL  = 1'b1;

    // Configuration reset values
    localparam logic [DT_W-1:0]          DT_RESET = 20'd26214;
    localparam logic signed [VOLT_W-1:0] EK_RESET = -16'sd23040;

    // Exponent scale factors, log2(e)/slope in Q0.16
    localparam logic [K_W-1:0] K_NINF  = 14'd10390;
    localparam logic [K_W-1:0] K_TAU_A = 14'd4357;
    localparam logic [K_W-1:0] K_TAU_B = 14'd6802;
    localparam logic [K_W-1:0] K_HINF  = 14'd9455;

    // Voltage offsets in Q16.16: -33.2 mV and +20 mV
    localparam logic signed [D_W-1:0] DM_OFFSET = -25'sd2175795;
    localparam logic signed [D_W-1:0] DH_OFFSET = 25'sd1310720;

    // Rate constants
    localparam logic [16:0]      HINF_BASE   = 17'd13107;
    localparam logic [16:0]      HINF_SCALE  = 17'd52429;
    localparam logic [17:0]      TAU_SCALE   = 18'd190054;
    localparam logic [12:0]      TAU_BASE    = 13'd6554;
    localparam logic [DIV_W-1:0] TWO32       = 64'h0000_0001_0000_0000;
    localparam logic [16:0]      POLY_SEED   = 17'd87;

    // Inactivation rate dt*2^12/6800: add half the divisor, drop 4 bits (6800 = 16*425),
    // then multiply by ceil(2^37/425) and keep the bits above 37; exact for 28-bit inputs
    localparam logic [11:0]      QH_ROUND    = 12'd3400;
    localparam logic [28:0]      QH_RECIP    = 29'd323385773;

    // Horner coefficients of the 2^f polynomial, outermost last
    function automatic logic [16:0] horner_coef(input logic [2:0] idx);
        logic [16:0] c;
        case (idx)
            3'd0:    c = 17'd630;
            3'd1:    c = 17'd3638;
            3'd2:    c = 17'd15744;
            3'd3:    c = 17'd45426;
            default: c = 17'd65536;
        endcase
        return c;
    endfunction

    // Q0.16 product with round to nearest
    function automatic logic [15:0] mulq16(input logic [15:0] a, input logic [15:0] b);
        logic [32:0] s;
        s = 33'(a * b) + 33'd32768;
        return s[31:16];
    endfunction

    typedef struct packed {
        logic                   start;
        logic signed [D_W-1:0]  d;
        logic [K_W-1:0]         k;
    } exp_req_t;

    typedef struct packed {
        logic             done;
        logic [EXP_W-1:0] value;
    } exp_rsp_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } div_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/kcg_exp_unit.sv =====
// Iterative 2^(d*k) unit: one multiply, five Horner steps, one final shift.
`default_nettype none

module kcg_exp_unit
    import kcg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  exp_req_t req,
    output exp_rsp_t rsp
);

    typedef enum logic [3:0] {
        EX_IDLE  = 4'b0001,
        EX_SPLIT = 4'b0010,
        EX_POLY  = 4'b0100,
        EX_SHIFT = 4'b1000
    } ex_state_t;

    ex_state_t state_reg, state_next;
    logic signed [39:0] prod_reg;
    logic [15:0]        f_reg;
    logic signed [7:0]  k_reg;
    logic [16:0]        p_reg;
    logic [2:0]         cnt_reg;
    logic [EXP_W-1:0]   value_reg;
    logic               done_reg;

    logic signed [14:0] k_s;
    logic signed [39:0] prod_full;
    logic [32:0]        pf;
    logic [17:0]        p_sum;
    logic signed [8:0]  sh;
    logic signed [8:0]  nsh;
    logic [5:0]         sh_amt;
    logic [EXP_W-1:0]   p64;
    logic [EXP_W-1:0]   shifted;

    // Exponent argument in log2 units
    assign k_s       = $signed({1'b0, req.k});
    assign prod_full = req.d * k_s;

    // One Horner step
    assign pf    = p_reg * f_reg;
    assign p_sum = 18'(horner_coef(cnt_reg)) + 18'(pf[32:16]);

    // Scale by 2^k with saturation above and flush below
    always_comb
    begin
        sh      = $signed({k_reg[7], k_reg}) + 9'sd16;
        nsh     = -sh;
        p64     = EXP_W'(p_reg);
        sh_amt  = 6'd0;
        shifted = '0;
        if (!sh[8])
        begin
            sh_amt  = (sh > 9'sd46) ? 6'd46 : sh[5:0];
            shifted = p64 << sh_amt;
        end
        else if (nsh < 9'sd63)
        begin
            sh_amt  = nsh[5:0];
            shifted = p64 >> sh_amt;
        end
    end

    // Sequence the unit
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            EX_IDLE:  if (req.start) state_next = EX_SPLIT;
            EX_SPLIT: state_next = EX_POLY;
            EX_POLY:  if (cnt_reg == 3'd4) state_next = EX_SHIFT;
            EX_SHIFT: state_next = EX_IDLE;
            default:  state_next = EX_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= EX_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == EX_SHIFT);
        end
    end

    // Datapath words
    always_ff @(posedge clk)
    begin
        if (state_reg == EX_IDLE && req.start)
            prod_reg <= prod_full;
        if (state_reg == EX_SPLIT)
        begin
            f_reg   <= prod_reg[31:16];
            k_reg   <= prod_reg[39:32];
            p_reg   <= POLY_SEED;
            cnt_reg <= 3'd0;
        end
        if (state_reg == EX_POLY)
        begin
            p_reg   <= p_sum[16:0];
            cnt_reg <= cnt_reg + 3'd1;
        end
        if (state_reg == EX_SHIFT)
            value_reg <= shifted;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = value_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/kcg_div_unit.sv =====
// Radix-2 restoring divider, 64-bit words, one quotient bit per cycle.
`default_nettype none

module kcg_div_unit
    import kcg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic             busy_reg;
    logic             done_reg;
    logic [5:0]       cnt_reg;
    logic [DIV_W-1:0] acc_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] den_reg;

    logic [DIV_W:0]   rem_sh;
    logic [DIV_W:0]   rem_diff;
    logic             ge;
    logic [DIV_W-1:0] rem_next;
    logic [DIV_W-1:0] acc_next;

    // Shift in one dividend bit, trial subtract
    assign rem_sh   = {rem_reg, acc_reg[DIV_W-1]};
    assign ge       = rem_sh >= {1'b0, den_reg};
    assign rem_diff = rem_sh - {1'b0, den_reg};
    assign rem_next = ge ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
    assign acc_next = {acc_reg[DIV_W-2:0], ge};

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!busy_reg && req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient builds up in the dividend register
    always_ff @(posedge clk)
    begin
        if (!busy_reg && req.start)
        begin
            acc_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = acc_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/kcg_gate_mem.sv =====
// Gate file: one synchronous memory holding {n, h} per compartment.
`default_nettype none

module kcg_gate_mem
    import kcg_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int IDX_W = 10
)
(
    input  logic                  clk,
    input  logic                  rd_en,
    input  logic [IDX_W-1:0]      rd_addr,
    output logic [2*GATE_W-1:0]   rd_data,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_addr,
    input  logic [2*GATE_W-1:0]   wr_data
);

    logic [2*GATE_W-1:0] mem [DEPTH];
    logic [2*GATE_W-1:0] rd_data_reg;

    // Write one word, read one word with a registered output
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/potassium_channel_gate_step_unit.sv =====
// Potassium gate step unit: each accepted request initializes or steps one compartment.
// Each exponential and each division holds the sequencer until it is done, divisions on the
// shared radix-2 divider: initialize runs 2 of each, a step 4 exponentials and 6 divisions;
// a gate whose numerator is not positive skips its division. busy is high from accept until
// the done cycle, done lasts one cycle and cannot be stalled; reset clears control and loads
// both registers, the gate file is not cleared.
`default_nettype none

module potassium_channel_gate_step_unit
    import kcg_pkg::*;
#(
    parameter int COMPARTMENTS = 1024
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      operation,
    input  logic [COMP_W-1:0]         compartment,
    input  logic signed [VOLT_W-1:0]  voltage,
    input  logic [15:0]               peak_conductance,
    input  logic                      cfg_write,
    input  logic                      cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    output logic                      done,
    output logic [15:0]               conductance,
    output logic signed [CUR_W-1:0]   current,
    output logic [GATE_W-1:0]         activation_gate,
    output logic [GATE_W-1:0]         inactivation_gate
);

    localparam int IDX_W    = (COMPARTMENTS > 1) ? $clog2(COMPARTMENTS) : 1;
    localparam int EXT_W    = (IDX_W > COMP_W) ? IDX_W : COMP_W;
    localparam bit POW2     = ((COMPARTMENTS & (COMPARTMENTS - 1)) == 0);
    localparam bit NEED_DIV = !POW2 && (COMPARTMENTS < (1 << COMP_W));
    localparam int RED_S    = COMP_W + IDX_W;
    localparam int RP_W     = 2 * COMP_W + 2;
    localparam logic [63:0] RED_M_FULL =
        ((64'd1 << RED_S) + 64'(COMPARTMENTS) - 64'd1) / 64'(COMPARTMENTS);
    localparam logic [COMP_W+1:0] RED_M = RED_M_FULL[COMP_W+1:0];

    typedef enum logic [21:0] {
        S_IDLE = 22'(1) << 0,
        S_IDX  = 22'(1) << 1,
        S_READ = 22'(1) << 2,
        S_EXN  = 22'(1) << 3,
        S_DVN  = 22'(1) << 4,
        S_EXH  = 22'(1) << 5,
        S_DVH  = 22'(1) << 6,
        S_EXA  = 22'(1) << 7,
        S_EXB  = 22'(1) << 8,
        S_DVT  = 22'(1) << 9,
        S_DVQN = 22'(1) << 10,
        S_DVQH = 22'(1) << 11,
        S_GMUL = 22'(1) << 12,
        S_GNUM = 22'(1) << 13,
        S_GDIV = 22'(1) << 14,
        S_WB   = 22'(1) << 15,
        S_MNN  = 22'(1) << 16,
        S_MN4  = 22'(1) << 17,
        S_MNH  = 22'(1) << 18,
        S_MG   = 22'(1) << 19,
        S_MI   = 22'(1) << 20,
        S_OUT  = 22'(1) << 21
    } seq_state_t;

    seq_state_t state_reg, state_next;
    logic       go_reg, go_next;

    logic [DT_W-1:0]          dt_reg;
    logic signed [VOLT_W-1:0] ek_reg;

    logic                      op_reg;
    logic signed [VOLT_W-1:0]  v_reg;
    logic [15:0]               gbar_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic [EXP_W-1:0]          ex_reg;
    logic [16:0]               ninf_reg;
    logic [16:0]               hinf_reg;
    logic [TAU_W-1:0]          tau_reg;
    logic [Q_W-1:0]            qn_reg;
    logic [Q_W-1:0]            qh_reg;
    logic                      gsel_reg;
    logic [51:0]               a_reg;
    logic signed [NUM_W-1:0]   num_reg;
    logic [GATE_W-1:0]         n_reg;
    logic [GATE_W-1:0]         h_reg;
    logic [15:0]               mp_reg;
    logic [15:0]               g_reg;
    logic signed [CUR_W-1:0]   cur_reg;

    exp_req_t exp_req;
    exp_rsp_t exp_rsp;
    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [EXT_W-1:0]          comp_ext;
    logic [RP_W-1:0]           red_prod;
    logic [RP_W-1:0]           red_quot;
    logic [RP_W-1:0]           red_rem;
    logic [IDX_W-1:0]          idx_direct;
    logic [31:0]               qh_num;
    logic [56:0]               qh_prod;
    logic signed [D_W-1:0]     vq;
    logic signed [D_W-1:0]     dm;
    logic signed [D_W-1:0]     dm_neg;
    logic signed [D_W-1:0]     dh;
    logic [DIV_W-1:0]          div_base;
    logic [DIV_W-1:0]          div_den;
    logic                      div_round;
    logic                      in_exp;
    logic                      in_div;
    logic                      gate_skip;
    logic [16:0]               inf_sel;
    logic [Q_W-1:0]            q_sel;
    logic [GATE_W-1:0]         gate_old;
    logic [2*GATE_W-1:0]       rd_data;
    logic signed [36:0]        qdiff;
    logic signed [53:0]        bprod;
    logic signed [NUM_W-1:0]   num_next;
    logic [GATE_W-1:0]         gate_val;
    logic [16:0]               hinf_next;
    logic signed [16:0]        vdiff;
    logic signed [33:0]        cprod;
    logic signed [CUR_W-1:0]   cur_sat;
    logic                      accept;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    // Index: 2^n masked; below 2^COMP_W reciprocal multiply and subtract back; else as is
    assign comp_ext   = EXT_W'(compartment);
    assign red_prod   = RP_W'(compartment) * RP_W'(RED_M);
    assign red_quot   = red_prod >> RED_S;
    assign red_rem    = RP_W'(compartment) - red_quot * RP_W'(COMPARTMENTS);
    assign idx_direct = POW2     ? (comp_ext[IDX_W-1:0] & IDX_W'(COMPARTMENTS - 1))
                      : NEED_DIV ? red_rem[IDX_W-1:0]
                                 : comp_ext[IDX_W-1:0];

    // Inactivation rate from the time step
    assign qh_num  = {dt_reg, 12'h000} + 32'(QH_ROUND);
    assign qh_prod = 57'(qh_num[31:4]) * 57'(QH_RECIP);

    // Voltage differences in Q16.16
    assign vq     = $signed({v_reg[VOLT_W-1], v_reg, 8'h00});
    assign dm     = DM_OFFSET - vq;
    assign dm_neg = -dm;
    assign dh     = vq + DH_OFFSET;

    // Gate being stepped
    assign inf_sel  = gsel_reg ? hinf_reg : ninf_reg;
    assign q_sel    = gsel_reg ? qh_reg : qn_reg;
    assign gate_old = gsel_reg ? rd_data[GATE_W-1:0] : rd_data[2*GATE_W-1:GATE_W];

    // Crank-Nicolson numerator: 2*inf*q + gate*(2^32 - q)
    assign qdiff     = 37'sd4294967296 - $signed({2'b00, q_sel});
    assign bprod     = $signed({1'b0, gate_old}) * qdiff;
    assign num_next  = $signed({3'b000, a_reg, 1'b0}) + NUM_W'(bprod);
    assign gate_skip = num_reg[NUM_W-1] || (num_reg == '0);
    assign gate_val  = gate_skip ? '0
                     : ((|div_rsp.quot[DIV_W-1:GATE_W]) ? '1 : div_rsp.quot[GATE_W-1:0]);

    assign hinf_next = HINF_BASE + div_rsp.quot[16:0];

    // Current with saturation to 32 bits
    assign vdiff   = $signed({v_reg[VOLT_W-1], v_reg}) - $signed({ek_reg[VOLT_W-1], ek_reg});
    assign cprod   = $signed({1'b0, g_reg}) * vdiff;
    assign cur_sat = (cprod[33:31] == 3'b000 || cprod[33:31] == 3'b111) ? cprod[31:0]
                   : (cprod[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

    // Unit requests
    assign in_exp = (state_reg == S_EXN) || (state_reg == S_EXH) ||
                    (state_reg == S_EXA) || (state_reg == S_EXB);
    assign in_div = (state_reg == S_DVN) || (state_reg == S_DVH) ||
                    (state_reg == S_DVT) || (state_reg == S_DVQN) ||
                    ((state_reg == S_GDIV) && !gate_skip);

    always_comb
    begin
        exp_req.start = in_exp && !go_reg;
        exp_req.d     = dm;
        exp_req.k     = K_NINF;
        unique case (state_reg)
            S_EXH:
            begin
                exp_req.d = dh;
                exp_req.k = K_HINF;
            end
            S_EXA:
            begin
                exp_req.k = K_TAU_A;
            end
            S_EXB:
            begin
                exp_req.d = dm_neg;
                exp_req.k = K_TAU_B;
            end
            default:
            begin
                exp_req.d = dm;
                exp_req.k = K_NINF;
            end
        endcase
    end

    // Divider operands, rounded to nearest
    always_comb
    begin
        div_den   = 64'd1;
        div_base  = '0;
        div_round = 1'b1;
        unique case (state_reg)
            S_DVN:
            begin
                div_den  = TWO32 + ex_reg;
                div_base = 64'd1 << 48;
            end
            S_DVH:
            begin
                div_den  = TWO32 + ex_reg;
                div_base = 64'(HINF_SCALE) << 32;
            end
            S_DVT:
            begin
                div_den  = (ex_reg == '0) ? 64'd1 : ex_reg;
                div_base = 64'(TAU_SCALE) << 32;
            end
            S_DVQN:
            begin
                div_den  = 64'(tau_reg);
                div_base = 64'(dt_reg) << 27;
            end
            S_GDIV:
            begin
                div_den  = TWO32 + 64'(q_sel);
                div_base = 64'(num_reg);
            end
            default:
            begin
                div_den   = 64'd1;
                div_base  = '0;
                div_round = 1'b0;
            end
        endcase
        div_req.start = in_div && !go_reg;
        div_req.den   = div_den;
        div_req.num   = div_base + (div_round ? (div_den >> 1) : '0);
    end

    // Track an outstanding unit request
    always_comb
    begin
        go_next = go_reg;
        if (exp_req.start || div_req.start)
            go_next = 1'b1;
        else if (exp_rsp.done || div_rsp.done)
            go_next = 1'b0;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (start) state_next = S_IDX;
            S_IDX:  state_next = S_READ;
            S_READ: state_next = S_EXN;
            S_EXN:  if (exp_rsp.done) state_next = S_DVN;
            S_DVN:  if (div_rsp.done) state_next = S_EXH;
            S_EXH:  if (exp_rsp.done) state_next = S_DVH;
            S_DVH:  if (div_rsp.done) state_next = op_reg ? S_EXA : S_WB;
            S_EXA:  if (exp_rsp.done) state_next = S_EXB;
            S_EXB:  if (exp_rsp.done) state_next = S_DVT;
            S_DVT:  if (div_rsp.done) state_next = S_DVQN;
            S_DVQN: if (div_rsp.done) state_next = S_DVQH;
            S_DVQH: state_next = S_GMUL;
            S_GMUL: state_next = S_GNUM;
            S_GNUM: state_next = S_GDIV;
            S_GDIV: if (gate_skip || div_rsp.done) state_next = gsel_reg ? S_WB : S_GMUL;
            S_WB:   state_next = S_MNN;
            S_MNN:  state_next = S_MN4;
            S_MN4:  state_next = S_MNH;
            S_MNH:  state_next = S_MG;
            S_MG:   state_next = S_MI;
            S_MI:   state_next = S_OUT;
            S_OUT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            go_reg    <= 1'b0;
            dt_reg    <= DT_RESET;
            ek_reg    <= EK_RESET;
        end
        else
        begin
            state_reg <= state_next;
            go_reg    <= go_next;
            // Configuration words
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_TIME_STEP: dt_reg <= cfg_data;
                    REG_REVERSAL:  ek_reg <= cfg_data[VOLT_W-1:0];
                    default:       dt_reg <= dt_reg;
                endcase
            end
        end
    end

    // Datapath words
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= operation;
            v_reg    <= voltage;
            gbar_reg <= peak_conductance;
            idx_reg  <= idx_direct;
            gsel_reg <= 1'b0;
        end

        // Exponentials; the two tau terms are summed
        if (exp_rsp.done)
        begin
            if (state_reg == S_EXB)
                ex_reg <= ex_reg + exp_rsp.value;
            else
                ex_reg <= exp_rsp.value;
        end

        // Division results
        if (div_rsp.done)
        begin
            unique case (state_reg)
                S_DVN:  ninf_reg <= div_rsp.quot[16:0];
                S_DVH:
                begin
                    hinf_reg <= hinf_next;
                    if (!op_reg)
                    begin
                        n_reg <= ninf_reg[16] ? '1 : ninf_reg[GATE_W-1:0];
                        h_reg <= hinf_next[16] ? '1 : hinf_next[GATE_W-1:0];
                    end
                end
                S_DVT:  tau_reg <= TAU_W'(div_rsp.quot) + TAU_W'(TAU_BASE);
                S_DVQN: qn_reg  <= div_rsp.quot[Q_W-1:0];
                default: ;
            endcase
        end
        if (state_reg == S_DVQH)
            qh_reg <= Q_W'(qh_prod[56:37]);

        // Gate step
        if (state_reg == S_GMUL)
            a_reg <= 52'(inf_sel) * 52'(q_sel);
        if (state_reg == S_GNUM)
            num_reg <= num_next;
        if (state_reg == S_GDIV && (gate_skip || div_rsp.done))
        begin
            if (gsel_reg)
                h_reg <= gate_val;
            else
                n_reg <= gate_val;
            gsel_reg <= 1'b1;
        end

        // Conductance and current
        if (state_reg == S_MNN)
            mp_reg <= mulq16(n_reg, n_reg);
        if (state_reg == S_MN4)
            mp_reg <= mulq16(mp_reg, mp_reg);
        if (state_reg == S_MNH)
            mp_reg <= mulq16(mp_reg, h_reg);
        if (state_reg == S_MG)
            g_reg <= mulq16(gbar_reg, mp_reg);
        if (state_reg == S_MI)
            cur_reg <= cur_sat;
    end

    kcg_exp_unit u_exp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (exp_req),
        .rsp   (exp_rsp)
    );

    kcg_div_unit u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    kcg_gate_mem #(
        .DEPTH (COMPARTMENTS),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .rd_en   (state_reg == S_READ),
        .rd_addr (idx_reg),
        .rd_data (rd_data),
        .wr_en   (state_reg == S_WB),
        .wr_addr (idx_reg),
        .wr_data ({n_reg, h_reg})
    );

    // Result word
    assign done              = (state_reg == S_OUT);
    assign conductance       = g_reg;
    assign current           = cur_reg;
    assign activation_gate   = n_reg;
    assign inactivation_gate = h_reg;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the potassium channel gate step unit.
`default_nettype none

module testbench
    import kcg_pkg::*;
();

    typedef struct {
        logic                     op;
        logic [COMP_W-1:0]        comp;
        logic signed [VOLT_W-1:0] volt;
        logic [15:0]              gbar;
    } gate_word_t;

    typedef struct {
        logic [15:0] g;
        logic [31:0] cur;
        logic [15:0] n;
        logic [15:0] h;
    } channel_word_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic                     operation;
    logic [COMP_W-1:0]        compartment;
    logic signed [VOLT_W-1:0] voltage;
    logic [15:0]              peak_conductance;
    logic                     cfg_write;
    logic                     cfg_index;
    logic [CFG_W-1:0]         cfg_data;
    logic                     done;
    logic [15:0]              conductance;
    logic signed [CUR_W-1:0]  current;
    logic [GATE_W-1:0]        activation_gate;
    logic [GATE_W-1:0]        inactivation_gate;

    potassium_channel_gate_step_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .compartment(compartment), .voltage(voltage),
        .peak_conductance(peak_conductance), .cfg_write(cfg_write),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
        .conductance(conductance), .current(current),
        .activation_gate(activation_gate), .inactivation_gate(inactivation_gate)
    );

    // Predictor state
    logic [15:0]  n_file [1024];
    logic [15:0]  h_file [1024];
    bit           seeded [1024];
    logic [19:0]  dt_reg;
    logic [15:0]  ek_reg;

    gate_word_t    pending_words[$];
    channel_word_t expected_words[$];
    int            fail_count;
    bit            idle_free;
    logic          busy_at_edge;

    function automatic longint floor16(longint p);
        if (p >= 0)
            return p >>> 16;
        return -((-p + 65535) >>> 16);
    endfunction

    // 2^y with y in Q16.16, result Q32.32
    function automatic longint unsigned pow2_q32(longint y);
        longint k;
        longint sh;
        longint unsigned f;
        longint unsigned p;
        k = floor16(y);
        f = longint'(y - k * 65536);
        p = 87;
        p = 630 + ((p * f) >> 16);
        p = 3638 + ((p * f) >> 16);
        p = 15744 + ((p * f) >> 16);
        p = 45426 + ((p * f) >> 16);
        p = 65536 + ((p * f) >> 16);
        sh = k + 16;
        if (sh > 46)
            sh = 46;
        if (sh >= 0)
            return p << sh;
        if (sh <= -63)
            return 0;
        return p >> (-sh);
    endfunction

    function automatic longint unsigned exp_of(longint d, longint k);
        return pow2_q32(floor16(d * k));
    endfunction

    function automatic longint unsigned rdiv(longint unsigned num, longint unsigned den);
        return (num + (den >> 1)) / den;
    endfunction

    function automatic longint unsigned cn_update(longint unsigned inf, longint unsigned gate,
                                                  longint unsigned q);
        longint num;
        longint unsigned r;
        num = longint'(2 * inf * q) + longint'(gate) * (64'sd4294967296 - longint'(q));
        if (num <= 0)
            return 0;
        r = rdiv(longint'(num), 64'd4294967296 + q);
        return (r > 65535) ? 65535 : r;
    endfunction

    function automatic longint unsigned rmul(longint unsigned a, longint unsigned b);
        return (a * b + 32768) >> 16;
    endfunction

    // Compute the channel word for one gate word and update the gate file
    function automatic channel_word_t channel_predict(gate_word_t w);
        channel_word_t r;
        longint v, e, vq, dm, dh, cur;
        longint unsigned ninf, hinf, s, tau, qn, qh, n, h, n2, nh, g;
        v = longint'(w.volt);
        e = longint'($signed(ek_reg));
        vq = v * 256;
        dm = -2175795 - vq;
        dh = vq + 1310720;
        ninf = rdiv(64'd281474976710656, 64'd4294967296 + exp_of(dm, 10390));
        hinf = 13107 + rdiv(64'd52429 << 32, 64'd4294967296 + exp_of(dh, 9455));
        if (w.op) begin
            s = exp_of(dm, 4357) + exp_of(-dm, 6802);
            if (s == 0)
                s = 1;
            tau = 6554 + rdiv(64'd190054 << 32, s);
            qn = rdiv(64'(dt_reg) << 27, tau);
            qh = rdiv(64'(dt_reg) << 12, 6800);
            n = cn_update(ninf, n_file[w.comp], qn);
            h = cn_update(hinf, h_file[w.comp], qh);
        end
        else begin
            n = (ninf > 65535) ? 65535 : ninf;
            h = (hinf > 65535) ? 65535 : hinf;
        end
        n_file[w.comp] = n[15:0];
        h_file[w.comp] = h[15:0];
        n2 = rmul(n, n);
        nh = rmul(rmul(n2, n2), h);
        g = rmul(w.gbar, nh);
        if (g > 65535)
            g = 65535;
        cur = longint'(g) * (v - e);
        if (cur > 64'sd2147483647)
            cur = 64'sd2147483647;
        if (cur < -64'sd2147483648)
            cur = -64'sd2147483648;
        r.g = g[15:0];
        r.cur = cur[31:0];
        r.n = n[15:0];
        r.h = h[15:0];
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Drive one gate word at a time from the pending queue
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (start && !busy_at_edge) begin
                start <= 1'b0;
            end
            else if (!start && pending_words.size() > 0
                     && (idle_free || $urandom_range(99) >= 37)) begin
                operation        <= pending_words[0].op;
                compartment      <= pending_words[0].comp;
                voltage          <= pending_words[0].volt;
                peak_conductance <= pending_words[0].gbar;
                start            <= 1'b1;
            end
        end
    end

    // Accept on the rising edge and predict
    always @(posedge clk)
    begin
        busy_at_edge <= busy;
        if (rst_n && start && !busy) begin
            gate_word_t w;
            w = pending_words.pop_front();
            expected_words.push_back(channel_predict(w));
        end
    end

    // Compare each result word against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done) begin
            if (expected_words.size() == 0) begin
                $error("result word with no prediction waiting");
                fail_count++;
            end
            else begin
                channel_word_t x;
                x = expected_words.pop_front();
                if (conductance !== x.g) begin
                    $error("conductance expected %0d actual %0d", x.g, conductance);
                    fail_count++;
                end
                if (current !== x.cur) begin
                    $error("current expected %0d actual %0d", $signed(x.cur), current);
                    fail_count++;
                end
                if (activation_gate !== x.n) begin
                    $error("activation_gate expected %0d actual %0d", x.n, activation_gate);
                    fail_count++;
                end
                if (inactivation_gate !== x.h) begin
                    $error("inactivation_gate expected %0d actual %0d", x.h,
                           inactivation_gate);
                    fail_count++;
                end
            end
        end
    end

    task automatic queue_word(logic op, int comp, int volt, int gbar);
        gate_word_t w;
        // never step a compartment whose gates were never initialized
        if (op && !seeded[comp])
            op = 1'b0;
        seeded[comp] = 1'b1;
        w.op = op;
        w.comp = comp[COMP_W-1:0];
        w.volt = volt[15:0];
        w.gbar = gbar[15:0];
        pending_words.push_back(w);
    endtask

    task automatic drain_and_wait();
        while (pending_words.size() > 0 || expected_words.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == REG_TIME_STEP)
            dt_reg = value;
        else
            ek_reg = value[15:0];
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic random_phase(int count);
        int c;
        for (int i = 0; i < count; i++) begin
            c = (($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(15));
            if ($urandom_range(3) == 0)
                queue_word(1'b0, c, $urandom, $urandom);
            else
                queue_word(1'b1, c, (($urandom_range(1) == 0) ? $urandom
                                     : int'($urandom_range(25600)) - 25600), $urandom);
        end
        drain_and_wait();
    endtask

    initial
    begin
        fail_count  = 0;
        idle_free   = 1'b0;
        start       = 1'b0;
        operation   = 1'b0;
        compartment = '0;
        voltage     = '0;
        peak_conductance = '0;
        cfg_write   = 1'b0;
        cfg_index   = REG_TIME_STEP;
        cfg_data    = '0;
        dt_reg      = DT_RESET;
        ek_reg      = EK_RESET;
        rst_n       = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes of voltage, conductance, compartment and both operations
        queue_word(1'b0, 0, -32768, 65535);
        queue_word(1'b1, 0, -32768, 65535);
        queue_word(1'b0, 1023, 32767, 65535);
        queue_word(1'b1, 1023, 32767, 0);
        queue_word(1'b0, 5, 0, 256);
        queue_word(1'b1, 5, -8499, 256);
        queue_word(1'b1, 5, -5120, 4096);
        queue_word(1'b0, 6, -23040, 65535);
        queue_word(1'b1, 6, 32767, 65535);
        queue_word(1'b1, 1023, -32768, 65535);
        drain_and_wait();

        // Large time step lets the gates overshoot and clamp; then a zero time step
        write_reg(REG_TIME_STEP, 20'hFFFFF);
        write_reg(REG_REVERSAL, 20'h08000);
        queue_word(1'b1, 0, 32767, 65535);
        queue_word(1'b1, 5, -32768, 65535);
        queue_word(1'b1, 6, 0, 65535);
        queue_word(1'b1, 1023, 20000, 12345);
        drain_and_wait();
        write_reg(REG_TIME_STEP, 20'd0);
        write_reg(REG_REVERSAL, 20'h07FFF);
        queue_word(1'b1, 0, -32768, 65535);
        queue_word(1'b1, 5, 32767, 65535);
        drain_and_wait();

        // Random phases across several settings, one with no idling
        write_reg(REG_TIME_STEP, DT_RESET);
        write_reg(REG_REVERSAL, 20'(EK_RESET) & 20'hFFFF);
        random_phase(400);
        idle_free = 1'b1;
        write_reg(REG_TIME_STEP, 20'($urandom_range(20'hFFFFF)));
        write_reg(REG_REVERSAL, 20'($urandom));
        random_phase(300);
        idle_free = 1'b0;
        write_reg(REG_TIME_STEP, 20'($urandom_range(1048575, 524288)));
        write_reg(REG_REVERSAL, 20'($urandom));
        random_phase(400);
        write_reg(REG_TIME_STEP, 20'($urandom_range(4000)));
        write_reg(REG_REVERSAL, 20'($urandom));
        random_phase(400);

        if (fail_count == 0)
            $display("PASS potassium_channel_gate_step_unit");
        else
            $display("FAIL potassium_channel_gate_step_unit");
        $finish;
    end

    // Safety limit on run length
    initial
    begin
        #80000000;
        $display("FAIL potassium_channel_gate_step_unit");
        $finish;
    end

endmodule

`default_nettype wire
